@@ sv/btmx_pkg.sv @@
// ----------------------------------------------------------------------------
// btmx_pkg: shared types and constants for the maximum-XOR trie engine
// Request and response beat layouts, status codes and default sizes.
// ----------------------------------------------------------------------------
package btmx_pkg;

    localparam int BTMX_KEY_BITS   = 32;
    localparam int BTMX_NODE_COUNT = 4096;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic        command;
        logic [31:0] key;
    } btmx_req_t;

    typedef struct packed {
        logic [31:0] best_xor;
        logic [1:0]  status;
    } btmx_rsp_t;

endpackage

@@ sv/btmx_node_store.sv @@
// ----------------------------------------------------------------------------
// btmx_node_store: child link store of the trie
// Synchronous memory of link pairs with a registered read. The
// root's pair lives in flip-flops so that it reads as empty after reset.
// ----------------------------------------------------------------------------
module btmx_node_store #(
    parameter int NODE_COUNT = btmx_pkg::BTMX_NODE_COUNT,
    parameter int NODE_W     = $clog2(NODE_COUNT)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [NODE_W-1:0]   rd_addr,
    output logic [2*NODE_W-1:0] rd_links,
    input  logic                wr_en,
    input  logic [NODE_W-1:0]   wr_addr,
    input  logic [2*NODE_W-1:0] wr_links
);
    import btmx_pkg::*;

    logic [2*NODE_W-1:0] mem [NODE_COUNT];
    logic [2*NODE_W-1:0] mem_rd_reg;
    logic [2*NODE_W-1:0] root_reg;
    logic                rd_root_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr != '0))
        begin
            mem[wr_addr] <= wr_links;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg    <= '0;
            rd_root_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && (wr_addr == '0))
            begin
                root_reg <= wr_links;
            end
            if (rd_en)
            begin
                rd_root_reg <= (rd_addr == '0);
            end
        end
    end

    assign rd_links = rd_root_reg ? root_reg : mem_rd_reg;

    // The walk never reads an entry in the same cycle as it rewrites it.
    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("node store read and write hit the same entry");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (int'(wr_addr) < NODE_COUNT))
        else $error("node store write beyond its depth");

    a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (int'(rd_addr) < NODE_COUNT))
        else $error("node store read beyond its depth");

endmodule

@@ sv/binary_trie_max_xor_engine.sv @@
// ----------------------------------------------------------------------------
// binary_trie_max_xor_engine: binary trie with maximum-XOR queries
// Steps: a query, or an insert whose whole path already exists, runs a root read,
// one node store read per level and a response load; an insert that allocates
// adds a write that links its first new node, then writes each new node's links.
// A full or empty case goes straight to the response load, which waits on rsp_stall.
// Flow: one item at a time; the next request beat is taken the cycle after
// the response is loaded.
// Reset: the trie is emptied (root only, no keys); the store is not swept.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_engine #(
    parameter int KEY_BITS   = btmx_pkg::BTMX_KEY_BITS,
    parameter int NODE_COUNT = btmx_pkg::BTMX_NODE_COUNT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  btmx_pkg::btmx_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output btmx_pkg::btmx_rsp_t rsp
);
    import btmx_pkg::*;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int USED_W = NODE_W + 1;
    localparam int LV_W   = $clog2(KEY_BITS);
    localparam logic [USED_W-1:0] FULL_LIMIT = USED_W'(NODE_COUNT - KEY_BITS);
    localparam logic [LV_W-1:0]   TOP_LEVEL  = LV_W'(KEY_BITS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_ALLOC,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] acc_reg, acc_next;
    logic [1:0]          status_reg, status_next;
    logic [LV_W-1:0]     level_reg, level_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [USED_W-1:0]   nodes_used_reg, nodes_used_next;
    logic                has_keys_reg, has_keys_next;
    logic                rsp_valid_reg, rsp_valid_next;
    btmx_rsp_t           rsp_reg, rsp_next;

    logic                rd_en;
    logic [NODE_W-1:0]   rd_addr;
    logic [2*NODE_W-1:0] rd_links;
    logic                wr_en;
    logic [NODE_W-1:0]   wr_addr;
    logic [2*NODE_W-1:0] wr_links;

    logic [NODE_W-1:0]   link_lo;
    logic [NODE_W-1:0]   link_hi;
    logic                cur_bit;
    logic                next_bit;
    logic [LV_W-1:0]     level_dn;
    logic [NODE_W-1:0]   same_link;
    logic [NODE_W-1:0]   other_link;
    logic [NODE_W-1:0]   fresh;
    logic                rsp_free;

    btmx_node_store #(
        .NODE_COUNT (NODE_COUNT),
        .NODE_W     (NODE_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_links (rd_links),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_links (wr_links)
    );

    assign link_lo    = rd_links[NODE_W-1:0];
    assign link_hi    = rd_links[2*NODE_W-1:NODE_W];
    assign cur_bit    = key_reg[level_reg];
    assign level_dn   = level_reg - 1'b1;
    assign next_bit   = key_reg[level_dn];
    assign same_link  = cur_bit ? link_hi : link_lo;
    assign other_link = cur_bit ? link_lo : link_hi;
    assign fresh      = nodes_used_reg[NODE_W-1:0];
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        acc_next        = acc_reg;
        status_next     = status_reg;
        level_next      = level_reg;
        node_next       = node_reg;
        nodes_used_next = nodes_used_reg;
        has_keys_next   = has_keys_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = node_reg;
        wr_links        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next    = req.command;
                    key_next    = KEY_BITS'(req.key);
                    acc_next    = '0;
                    status_next = STATUS_OK;
                    level_next  = TOP_LEVEL;
                    node_next   = '0;
                    if ((req.command == CMD_INSERT) && (nodes_used_reg > FULL_LIMIT))
                    begin
                        status_next = STATUS_FULL;
                        state_next  = S_DONE;
                    end
                    else if ((req.command == CMD_QUERY) && !has_keys_reg)
                    begin
                        status_next = STATUS_EMPTY;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        if (req.command == CMD_INSERT)
                        begin
                            has_keys_next = 1'b1;
                        end
                        // Fetch the root's links for the first level.
                        rd_en      = 1'b1;
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                if (cmd_reg == CMD_QUERY)
                begin
                    if (other_link != '0)
                    begin
                        acc_next[level_reg] = 1'b1;
                        node_next           = other_link;
                    end
                    else
                    begin
                        node_next = same_link;
                    end
                    if (level_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = node_next;
                        level_next = level_dn;
                    end
                end
                else if (same_link != '0)
                begin
                    node_next = same_link;
                    if (level_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = same_link;
                        level_next = level_dn;
                    end
                end
                else
                begin
                    // Missing child: hang a fresh node here and build the rest
                    // of the path from fresh nodes, which have no children.
                    wr_en           = 1'b1;
                    wr_links        = cur_bit ? {fresh, link_lo} : {link_hi, fresh};
                    node_next       = fresh;
                    nodes_used_next = nodes_used_reg + 1'b1;
                    state_next      = S_ALLOC;
                end
            end

            S_ALLOC:
            begin
                wr_en = 1'b1;
                if (level_reg == '0)
                begin
                    wr_links   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    wr_links        = next_bit ? {fresh, NODE_W'(0)} : {NODE_W'(0), fresh};
                    node_next       = fresh;
                    nodes_used_next = nodes_used_reg + 1'b1;
                    level_next      = level_dn;
                end
            end

            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next.best_xor = 32'(acc_reg);
                    rsp_next.status   = status_reg;
                    rsp_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            nodes_used_reg <= USED_W'(1);
            has_keys_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nodes_used_reg <= nodes_used_next;
            has_keys_reg   <= has_keys_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        acc_reg    <= acc_next;
        status_reg <= status_next;
        level_reg  <= level_next;
        node_reg   <= node_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(nodes_used_reg) <= NODE_COUNT)
        else $error("allocation ran past the node store");

    a_used_only_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(nodes_used_reg) |->
            ($past(state_reg == S_WALK || state_reg == S_ALLOC) && $past(cmd_reg == CMD_INSERT)))
        else $error("node count moved outside an insert walk");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status != STATUS_OK)) |-> (rsp_reg.best_xor == '0))
        else $error("refused item carries a non-zero result");

    a_empty_only_before_insert: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) && (rsp_reg.status == STATUS_EMPTY) |-> !has_keys_reg)
        else $error("empty status given with keys stored");

endmodule

@@ test/tb_binary_trie_max_xor_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_trie_max_xor_engine: self-checking bench for the max-XOR trie
// Drives insert and query beats with random gaps and response stalls, keeps
// its own copy of the trie to predict every response, and compares each
// response beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_binary_trie_max_xor_engine;

    import btmx_pkg::*;

    localparam int RANDOM_ITEMS = 1930;

    class trie_scoreboard;
        int unsigned links[BTMX_NODE_COUNT][2];
        int          nodes_used;
        bit          has_keys;
        btmx_rsp_t   expected_q[$];
        int          fail_count;

        function new();
            links[0][0] = 0;
            links[0][1] = 0;
            nodes_used  = 1;
            has_keys    = 1'b0;
            fail_count  = 0;
        endfunction

        // Works out the response to an accepted request beat and updates the trie.
        function void note_request(btmx_req_t beat);
            btmx_rsp_t   want;
            int unsigned node;
            bit          b;
            want.best_xor = '0;
            want.status   = STATUS_OK;
            node          = 0;
            if (beat.command == CMD_INSERT)
            begin
                // A refused insert leaves the trie untouched, even for a known key.
                if (BTMX_NODE_COUNT - nodes_used < BTMX_KEY_BITS)
                    want.status = STATUS_FULL;
                else
                begin
                    for (int lv = BTMX_KEY_BITS - 1; lv >= 0; lv--)
                    begin
                        b = beat.key[lv];
                        if (links[node][b] == 0)
                        begin
                            links[nodes_used][0] = 0;
                            links[nodes_used][1] = 0;
                            links[node][b] = nodes_used;
                            nodes_used++;
                        end
                        node = links[node][b];
                    end
                    has_keys = 1'b1;
                end
            end
            else if (!has_keys)
                want.status = STATUS_EMPTY;
            else
            begin
                for (int lv = BTMX_KEY_BITS - 1; lv >= 0; lv--)
                begin
                    b = beat.key[lv];
                    if (links[node][!b] != 0)
                    begin
                        node = links[node][!b];
                        want.best_xor[lv] = 1'b1;
                    end
                    else
                        node = links[node][b];
                end
            end
            expected_q = {expected_q, want};
        endfunction

        function void check_response(btmx_rsp_t beat);
            btmx_rsp_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected response beat: best_xor %h, status %0d",
                       beat.best_xor, beat.status);
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            if (beat.best_xor !== want.best_xor)
            begin
                $error("best_xor: expected %h, actual %h", want.best_xor, beat.best_xor);
                fail_count++;
            end
            if (beat.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, beat.status);
                fail_count++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    btmx_req_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    btmx_rsp_t rsp;

    trie_scoreboard sb;
    bit             send_burst;
    bit             take_burst;
    logic [31:0]    key_pool[16];
    int             pool_count;

    binary_trie_max_xor_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            sb.note_request(req);
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
    end

    task automatic send_item(input logic cmd, input logic [31:0] key);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid   <= 1'b1;
        req.command <= cmd;
        req.key     <= key;
        do @(posedge clk); while (!(req_valid && !req_stall));
    endtask

    // Keys cluster around recently inserted ones so that paths share prefixes
    // and queries land on deep branches; the rest are fresh random patterns or all-zero and all-one keys.
    function automatic logic [31:0] draw_key(input bit for_query);
        logic [31:0] base;
        int          pick;
        if (pool_count == 0)
            return $urandom;
        base = key_pool[$urandom_range(0, pool_count - 1)];
        pick = $urandom_range(0, 5);
        case (pick)
            0, 1: return $urandom;
            2:    return base ^ ($urandom & ((32'd1 << $urandom_range(0, 12)) - 1));
            3:    return base ^ (32'd1 << $urandom_range(0, 31));
            4:    return for_query ? ~base : base;
            default: return ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        endcase
    endfunction

    initial
    begin
        int hold;
        int beats;
        rsp_stall = 1'b0;
        beats     = 0;
        @(posedge rst_n);
        forever
        begin
            if (beats % 50 == 0)
                take_burst = ($urandom_range(0, 3) == 0);
            hold = take_burst ? 0 : $urandom_range(0, 10);
            repeat (hold)
            begin
                @(negedge clk);
                rsp_stall <= 1'b1;
            end
            @(negedge clk);
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!(rsp_valid && !rsp_stall));
            beats++;
        end
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic        cmd;
        logic [31:0] key;
        sb         = new();
        clk        = 1'b0;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        send_burst = 1'b0;
        take_burst = 1'b0;
        pool_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Queries on an empty trie, then the extreme keys and alternating patterns.
        send_item(CMD_QUERY,  32'h0000_0000);
        send_item(CMD_QUERY,  32'hFFFF_FFFF);
        send_item(CMD_INSERT, 32'h0000_0000);
        send_item(CMD_QUERY,  32'h0000_0000);
        send_item(CMD_QUERY,  32'hFFFF_FFFF);
        send_item(CMD_INSERT, 32'hFFFF_FFFF);
        send_item(CMD_INSERT, 32'h0000_0000);
        send_item(CMD_QUERY,  32'h0000_FFFF);
        send_item(CMD_QUERY,  32'hFFFF_FFFF);
        send_item(CMD_INSERT, 32'h8000_0000);
        send_item(CMD_INSERT, 32'h0000_0001);
        send_item(CMD_INSERT, 32'h7FFF_FFFF);
        send_item(CMD_INSERT, 32'hAAAA_AAAA);
        send_item(CMD_INSERT, 32'h5555_5555);
        send_item(CMD_QUERY,  32'h8000_0000);
        send_item(CMD_QUERY,  32'h5555_5555);
        send_item(CMD_QUERY,  32'hAAAA_AAAA);
        send_item(CMD_QUERY,  32'h1234_5678);
        send_item(CMD_QUERY,  32'hDEAD_BEEF);
        send_item(CMD_QUERY,  32'h0000_0001);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
                send_burst = ($urandom_range(0, 3) == 0);
            // Let the engine drain completely once, mid-run, with the request
            // side idle so that the last beat is not offered again.
            if (i == RANDOM_ITEMS / 2)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                while (sb.pending() != 0) @(negedge clk);
            end
            if ($urandom_range(0, 99) < 35)
            begin
                cmd = CMD_INSERT;
                key = draw_key(1'b0);
                key_pool[pool_count < 16 ? pool_count : $urandom_range(0, 15)] = key;
                if (pool_count < 16)
                    pool_count++;
            end
            else
            begin
                cmd = CMD_QUERY;
                key = draw_key(1'b1);
            end
            send_item(cmd, key);
        end
        @(negedge clk);
        req_valid <= 1'b0;

        while (sb.pending() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (sb.fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
